>>> hw/rtl/lge_pkg.sv
// lge_pkg: constants, types and codes shared by the lattice gas exchange block
// no dependencies; compiled first
package lge_pkg;

    // lattice size and derived widths
    localparam int SITES      = 1024;
    localparam int SITE_W     = $clog2(SITES);
    localparam int NBR_SLOTS  = 4;
    localparam int DIR_W      = $clog2(NBR_SLOTS);
    localparam int TBL_DEPTH  = SITES * NBR_SLOTS;
    localparam int TBL_AW     = SITE_W + DIR_W;

    // word fields
    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 10;
    localparam int RND_W      = 32;
    localparam int DE_W       = 5;

    // threshold registers
    localparam int THR_COUNT  = 8;
    localparam int THR_W      = 32;
    localparam int THR_IW     = $clog2(THR_COUNT);
    localparam int CFG_AW     = THR_IW + 2;
    localparam int CFG_DW     = 32;

    // occupancy bits gathered for one exchange: a, b, a's four, b's four
    localparam int OCC_A      = 0;
    localparam int OCC_B      = 1;
    localparam int OCC_NA     = 2;
    localparam int OCC_NB     = OCC_NA + NBR_SLOTS;
    localparam int OCC_BITS   = OCC_NB + NBR_SLOTS;
    localparam int CNT_W      = $clog2(OCC_BITS + 1);

    typedef logic [MODE_W-1:0]                t_mode;
    typedef logic [SITE_W-1:0]                t_site;
    typedef logic [DIR_W-1:0]                 t_dir;
    typedef logic [VALUE_W-1:0]               t_value;
    typedef logic [RND_W-1:0]                 t_rnd;
    typedef logic signed [DE_W-1:0]           t_de;
    typedef logic [NBR_SLOTS-1:0][SITE_W-1:0] t_nbr_set;
    typedef logic [THR_COUNT-1:0][THR_W-1:0]  t_thr_arr;

    // item modes
    localparam t_mode MODE_NBR_WR   = 2'd0;
    localparam t_mode MODE_OCC_WR   = 2'd1;
    localparam t_mode MODE_EXCHANGE = 2'd2;
    localparam t_mode MODE_OCC_RD   = 2'd3;

    // threshold reset values, exp(-beta*J*k) in UQ0.32, rise 8 at the top
    localparam t_thr_arr THR_RESET = {
        32'd471140733,  32'd621052271,  32'd818659421,  32'd1079144893,
        32'd1422510349, 32'd1875126887, 32'd2471767578, 32'd3258243795
    };

    // neighbour table memory request
    typedef struct packed {
        logic               we;
        logic [TBL_AW-1:0]  waddr;
        t_site              wdata;
        logic [TBL_AW-1:0]  raddr;
    } t_tbl_req;

    // occupancy memory request
    typedef struct packed {
        logic  we;
        t_site waddr;
        logic  wdata;
        t_site raddr;
    } t_occ_req;

    // outcome of one proposal
    typedef struct packed {
        logic keep;
        t_de  de;
    } t_verdict;

endpackage

>>> hw/rtl/lge_if.sv
// lge_in_if, lge_out_if: valid/ready channels for input and result words
// depends on lge_pkg
interface lge_in_if;
    import lge_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_site  site;
    t_dir   direction;
    t_value value;
    t_rnd   random;

    modport source (output valid, mode, site, direction, value, random, input ready);
    modport sink   (input valid, mode, site, direction, value, random, output ready);
endinterface

interface lge_out_if;
    import lge_pkg::*;

    logic valid;
    logic ready;
    logic accepted;
    t_de  delta_energy;
    logic read_value;

    modport source (output valid, accepted, delta_energy, read_value, input ready);
    modport sink   (input valid, accepted, delta_energy, read_value, output ready);
endinterface

>>> hw/rtl/lge_ram.sv
// lge_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module lge_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/lge_cfg_regs.sv
// lge_cfg_regs: APB-style register bank holding the eight acceptance thresholds
// depends on lge_pkg
module lge_cfg_regs (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [lge_pkg::CFG_AW-1:0] paddr,
    input  logic [lge_pkg::CFG_DW-1:0] pwdata,
    output logic [lge_pkg::CFG_DW-1:0] prdata,
    output logic                    pready,
    output lge_pkg::t_thr_arr       o_thr
);
    import lge_pkg::*;

    t_thr_arr           r_thr;
    logic [THR_IW-1:0]  w_idx;

    // word address selects the register
    assign w_idx = paddr[CFG_AW-1:2];

    // threshold registers, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite) begin
            r_thr[w_idx] <= pwdata;
        end
    end

    assign prdata = r_thr[w_idx];
    assign pready = 1'b1;
    assign o_thr  = r_thr;
endmodule

>>> hw/rtl/lge_energy.sv
// lge_energy: local energy change of a proposed swap and the metropolis verdict
// depends on lge_pkg
module lge_energy (
    input  lge_pkg::t_site                  i_site_a,
    input  lge_pkg::t_site                  i_site_b,
    input  lge_pkg::t_nbr_set               i_na,
    input  lge_pkg::t_nbr_set               i_nb,
    input  logic [lge_pkg::OCC_BITS-1:0]    i_occ,
    input  lge_pkg::t_rnd                   i_random,
    input  lge_pkg::t_thr_arr               i_thr,
    output lge_pkg::t_verdict               o_verdict
);
    import lge_pkg::*;

    logic              oa;
    logic              ob;
    logic [2:0]        sa;
    logic [2:0]        sb;
    logic [2:0]        sa_sw;
    logic [2:0]        sb_sw;
    logic [3:0]        p_before;
    logic [3:0]        p_after;
    t_de               de;
    logic              rise;
    logic [THR_IW-1:0] idx;

    // neighbour sums before and after the swap of a and b
    always_comb begin
        oa    = i_occ[OCC_A];
        ob    = i_occ[OCC_B];
        sa    = '0;
        sb    = '0;
        sa_sw = '0;
        sb_sw = '0;
        for (int k = 0; k < NBR_SLOTS; k++) begin
            sa = sa + {2'b00, i_occ[OCC_NA + k]};
            sb = sb + {2'b00, i_occ[OCC_NB + k]};
            if (i_na[k] == i_site_a) begin
                sa_sw = sa_sw + {2'b00, ob};
            end else if (i_na[k] == i_site_b) begin
                sa_sw = sa_sw + {2'b00, oa};
            end else begin
                sa_sw = sa_sw + {2'b00, i_occ[OCC_NA + k]};
            end
            if (i_nb[k] == i_site_a) begin
                sb_sw = sb_sw + {2'b00, ob};
            end else if (i_nb[k] == i_site_b) begin
                sb_sw = sb_sw + {2'b00, oa};
            end else begin
                sb_sw = sb_sw + {2'b00, i_occ[OCC_NB + k]};
            end
        end
        p_before = (oa ? {1'b0, sa} : 4'd0) + (ob ? {1'b0, sb} : 4'd0);
        p_after  = (ob ? {1'b0, sa_sw} : 4'd0) + (oa ? {1'b0, sb_sw} : 4'd0);
    end

    // energy is minus the pair count, so delta is before minus after
    assign de   = {1'b0, p_before} - {1'b0, p_after};
    assign rise = !de[DE_W-1] && (de != '0);
    // rise of 1..8 maps to threshold 0..7
    assign idx  = de[THR_IW-1:0] - THR_IW'(1);

    assign o_verdict.de   = de;
    assign o_verdict.keep = !rise || (i_random < i_thr[idx]);
endmodule

>>> hw/rtl/lge_ctrl.sv
// lge_ctrl: sequencer that reads, updates and writes back the two state memories
// depends on lge_pkg, lge_if and lge_energy
module lge_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lge_in_if.sink               i_in,
    lge_out_if.source            o_out,
    input  lge_pkg::t_thr_arr    i_thr,
    output lge_pkg::t_tbl_req    o_tbl_req,
    input  lge_pkg::t_site       i_tbl_rdata,
    output lge_pkg::t_occ_req    o_occ_req,
    input  logic                 i_occ_rdata
);
    import lge_pkg::*;

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_CLR   = 4'd0;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] S_TBL_A = 4'd2;
    localparam logic [STATE_W-1:0] S_TBL_B = 4'd3;
    localparam logic [STATE_W-1:0] S_OCC   = 4'd4;
    localparam logic [STATE_W-1:0] S_CALC  = 4'd5;
    localparam logic [STATE_W-1:0] S_WR_A  = 4'd6;
    localparam logic [STATE_W-1:0] S_WR_B  = 4'd7;
    localparam logic [STATE_W-1:0] S_RD    = 4'd8;
    localparam logic [STATE_W-1:0] S_DONE  = 4'd9;

    logic [STATE_W-1:0]  r_state;
    logic [STATE_W-1:0]  n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    t_site               r_clr;
    t_mode               r_mode;
    t_site               r_site;
    t_dir                r_dir;
    t_rnd                r_rnd;
    t_nbr_set            r_na;
    t_nbr_set            r_nb;
    logic [OCC_BITS-1:0] r_occ;
    logic                r_res_acc;
    t_de                 r_res_de;
    logic                r_res_rd;
    logic                r_out_valid;
    logic                r_out_acc;
    t_de                 r_out_de;
    logic                r_out_rd;

    logic                w_accept;
    logic                w_out_free;
    t_site               w_b;
    t_dir                w_k;
    t_site               w_occ_addr;
    t_verdict            w_verdict;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_b        = r_na[r_dir];
    // same slot index for a's group (codes 2..5) and b's group (6..9)
    assign w_k        = r_cnt[DIR_W-1:0] - DIR_W'(OCC_NA);

    // site whose occupancy is fetched at this step
    always_comb begin
        case (r_cnt) inside
            CNT_W'(OCC_A): w_occ_addr = r_site;
            CNT_W'(OCC_B): w_occ_addr = w_b;
            CNT_W'(2), CNT_W'(3), CNT_W'(4), CNT_W'(5): w_occ_addr = r_na[w_k];
            CNT_W'(6), CNT_W'(7), CNT_W'(8), CNT_W'(9): w_occ_addr = r_nb[w_k];
            default: w_occ_addr = r_site;
        endcase
    end

    // energy and verdict from the gathered bits
    lge_energy u_energy (
        .i_site_a  (r_site),
        .i_site_b  (w_b),
        .i_na      (r_na),
        .i_nb      (r_nb),
        .i_occ     (r_occ),
        .i_random  (r_rnd),
        .i_thr     (i_thr),
        .o_verdict (w_verdict)
    );

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == t_site'(SITES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    unique case (i_in.mode)
                        MODE_NBR_WR, MODE_OCC_WR: n_state = S_DONE;
                        MODE_OCC_RD:              n_state = S_RD;
                        MODE_EXCHANGE:            n_state = S_TBL_A;
                        default:                  n_state = S_DONE;
                    endcase
                end
            end
            S_TBL_A: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NBR_SLOTS)) begin
                    n_state = S_TBL_B;
                    n_cnt   = '0;
                end
            end
            S_TBL_B: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NBR_SLOTS)) begin
                    n_state = S_OCC;
                    n_cnt   = '0;
                end
            end
            S_OCC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(OCC_BITS)) begin
                    n_state = S_CALC;
                    n_cnt   = '0;
                end
            end
            S_CALC:  n_state = S_WR_A;
            S_WR_A:  n_state = S_WR_B;
            S_WR_B:  n_state = S_DONE;
            S_RD:    n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // neighbour table port
    always_comb begin
        o_tbl_req.we    = w_accept && (i_in.mode == MODE_NBR_WR);
        o_tbl_req.waddr = {i_in.site, i_in.direction};
        o_tbl_req.wdata = t_site'(i_in.value);
        o_tbl_req.raddr = {r_site, r_cnt[DIR_W-1:0]};
        if (r_state == S_TBL_B) begin
            o_tbl_req.raddr = {w_b, r_cnt[DIR_W-1:0]};
        end
    end

    // occupancy port: clearing pass, direct writes and reads, gather and write back
    always_comb begin
        o_occ_req.we    = w_accept && (i_in.mode == MODE_OCC_WR);
        o_occ_req.waddr = i_in.site;
        o_occ_req.wdata = i_in.value[0];
        o_occ_req.raddr = (r_state == S_OCC) ? w_occ_addr : i_in.site;
        unique case (r_state)
            S_CLR: begin
                o_occ_req.we    = 1'b1;
                o_occ_req.waddr = r_clr;
                o_occ_req.wdata = 1'b0;
            end
            S_WR_A: begin
                o_occ_req.we    = r_res_acc;
                o_occ_req.waddr = r_site;
                o_occ_req.wdata = r_occ[OCC_B];
            end
            S_WR_B: begin
                o_occ_req.we    = r_res_acc;
                o_occ_req.waddr = w_b;
                o_occ_req.wdata = r_occ[OCC_A];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + t_site'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured word, gathered data and result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode    <= i_in.mode;
            r_site    <= i_in.site;
            r_dir     <= i_in.direction;
            r_rnd     <= i_in.random;
            r_res_acc <= 1'b0;
            r_res_de  <= '0;
            r_res_rd  <= 1'b0;
        end
        if (r_state == S_TBL_A && r_cnt != '0) begin
            r_na[DIR_W'(r_cnt - CNT_W'(1))] <= i_tbl_rdata;
        end
        if (r_state == S_TBL_B && r_cnt != '0) begin
            r_nb[DIR_W'(r_cnt - CNT_W'(1))] <= i_tbl_rdata;
        end
        if (r_state == S_OCC && r_cnt != '0) begin
            r_occ[r_cnt - CNT_W'(1)] <= i_occ_rdata;
        end
        if (r_state == S_CALC) begin
            r_res_acc <= w_verdict.keep;
            r_res_de  <= w_verdict.de;
        end
        if (r_state == S_RD && r_mode == MODE_OCC_RD) begin
            r_res_rd <= i_occ_rdata;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_acc <= r_res_acc;
            r_out_de  <= r_res_de;
            r_out_rd  <= r_res_rd;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_out_acc;
    assign o_out.delta_energy = r_out_de;
    assign o_out.read_value   = r_out_rd;
endmodule

>>> hw/rtl/lattice_gas_exchange_metropolis.sv
// Accepted word to result word: table and occupancy writes go straight to the result,
// an occupancy read passes a read state, an exchange makes 4+4 neighbour reads and 10
// occupancy reads on single-read-port memories, a verdict state, then write-back of a and b.
// One word at a time; the next is taken the cycle after a result is registered.
// Reset: thresholds take their defaults, then a clearing pass empties every site before
// the first word is taken; the neighbour table is not cleared.
module lattice_gas_exchange_metropolis (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lge_in_if.sink                     i_in,
    lge_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lge_pkg::CFG_AW-1:0] paddr,
    input  logic [lge_pkg::CFG_DW-1:0] pwdata,
    output logic [lge_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import lge_pkg::*;

    t_thr_arr w_thr;
    t_tbl_req w_tbl_req;
    t_site    w_tbl_rdata;
    t_occ_req w_occ_req;
    logic     w_occ_rdata;

    // threshold registers
    lge_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (w_thr)
    );

    // sequencer
    lge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_thr       (w_thr),
        .o_tbl_req   (w_tbl_req),
        .i_tbl_rdata (w_tbl_rdata),
        .o_occ_req   (w_occ_req),
        .i_occ_rdata (w_occ_rdata)
    );

    // four-slot neighbour table
    lge_ram #(
        .WIDTH (SITE_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (w_tbl_req.we),
        .i_waddr (w_tbl_req.waddr),
        .i_wdata (w_tbl_req.wdata),
        .i_raddr (w_tbl_req.raddr),
        .o_rdata (w_tbl_rdata)
    );

    // one occupancy bit per site
    lge_ram #(
        .WIDTH (1),
        .DEPTH (SITES)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (w_occ_req.we),
        .i_waddr (w_occ_req.waddr),
        .i_wdata (w_occ_req.wdata),
        .i_raddr (w_occ_req.raddr),
        .o_rdata (w_occ_rdata)
    );
endmodule

>>> tb/tb_top.sv
// tb_top: self-checking regression for lattice_gas_exchange_metropolis
// drives word channels and the apb threshold port, predicts every result word in-line
// depends on lge_pkg, lge_in_if, lge_out_if and the block itself
module tb_top;
    import lge_pkg::*;

    // a run of cycles with no accepted word, taken result or register access longer than this
    // ends the run; covers the clearing pass and the long output hold-off several times over
    localparam int STALL_LIMIT   = 5000;
    localparam int REGION_SITES  = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum {THR_RANDOM, THR_EVEN_ZERO, THR_ODD_ZERO} t_thr_setting;

    typedef struct packed {
        logic accepted;
        t_de  delta_energy;
        logic read_value;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    lge_in_if  word_in ();
    lge_out_if word_out ();

    lattice_gas_exchange_metropolis dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_in),
        .o_out   (word_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // lattice model: occupancy, neighbour table with written flags, thresholds
    bit       occ_model   [SITES];
    t_site    nbr_model   [TBL_DEPTH];
    bit       nbr_loaded  [TBL_DEPTH];
    t_thr_arr thr_model;

    t_outcome expected_outcomes [$];
    t_site    lattice_region [$];

    int mismatch_count;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int stuck_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // local energy of the pair, neighbours double counted
    function automatic int pair_energy(input t_site a, input t_site b);
        int sum_a;
        int sum_b;
        sum_a = 0;
        sum_b = 0;
        for (int k = 0; k < NBR_SLOTS; k++) begin
            sum_a += occ_model[nbr_model[{a, t_dir'(k)}]];
            sum_b += occ_model[nbr_model[{b, t_dir'(k)}]];
        end
        return -(int'(occ_model[a]) * sum_a) - (int'(occ_model[b]) * sum_b);
    endfunction

    // apply one word to the lattice model and return the result word it causes
    function automatic t_outcome predict_outcome(input t_mode m, input t_site s,
                                                 input t_dir d, input t_value v,
                                                 input t_rnd r);
        t_outcome o;
        t_site    b;
        int       e_before;
        int       de;
        bit       held;
        bit       keep;
        o = '0;
        case (m)
            MODE_NBR_WR: begin
                nbr_model[{s, d}]  = t_site'(v);
                nbr_loaded[{s, d}] = 1'b1;
            end
            MODE_OCC_WR: begin
                occ_model[s] = v[0];
            end
            MODE_OCC_RD: begin
                o.read_value = occ_model[s];
            end
            default: begin
                b = nbr_model[{s, d}];
                e_before = pair_energy(s, b);
                held = occ_model[s];
                occ_model[s] = occ_model[b];
                occ_model[b] = held;
                de = pair_energy(s, b) - e_before;
                if (de > 8) de = 8;
                if (de < -8) de = -8;
                if (de <= 0) keep = 1'b1;
                else keep = (r < thr_model[de-1]);
                // rejected: put the pair back
                if (!keep) begin
                    occ_model[b] = occ_model[s];
                    occ_model[s] = held;
                end
                o.accepted     = keep;
                o.delta_energy = t_de'(de);
            end
        endcase
        return o;
    endfunction

    // an exchange only reads table entries that have been written
    function automatic bit exchange_safe(input t_site a, input t_dir d);
        t_site b;
        for (int k = 0; k < NBR_SLOTS; k++)
            if (!nbr_loaded[{a, t_dir'(k)}]) return 1'b0;
        b = nbr_model[{a, d}];
        for (int k = 0; k < NBR_SLOTS; k++)
            if (!nbr_loaded[{b, t_dir'(k)}]) return 1'b0;
        return 1'b1;
    endfunction

    // random value: half uniform, some at the extremes, some at or one off a threshold
    function automatic t_rnd draw_uniform();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: return '0;
            1: return '1;
            2, 3: return thr_model[$urandom_range(THR_COUNT-1)]
                         + t_rnd'($urandom_range(2)) - t_rnd'(1);
            default: return t_rnd'($urandom);
        endcase
    endfunction

    // offer one word, hold it until taken, then record its expected result
    task automatic send_word(input t_mode m, input t_site s, input t_dir d,
                             input t_value v, input t_rnd r);
        while ($urandom_range(99) < send_idle_pct) begin
            word_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_in.valid     <= 1'b1;
        word_in.mode      <= m;
        word_in.site      <= s;
        word_in.direction <= d;
        word_in.value     <= v;
        word_in.random    <= r;
        do @(posedge i_clk); while (!word_in.ready);
        expected_outcomes.push_back(predict_outcome(m, s, d, v, r));
    endtask

    // stop offering and wait for every outstanding result word
    task automatic wait_drained();
        word_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_outcomes.size() != 0);
    endtask

    // apb write: setup phase, access phase, then idle
    task automatic apb_write(input int idx, input logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input int idx, output logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_AW'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_thresholds();
        logic [CFG_DW-1:0] rd;
        for (int i = 0; i < THR_COUNT; i++) begin
            apb_read(i, rd);
            if (rd !== thr_model[i]) report_mismatch("threshold readback", rd, thr_model[i]);
        end
    endtask

    // result checker and receiver ready, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && word_out.valid && word_out.ready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result word with nothing expected", 0, 0);
            end else begin
                t_outcome want;
                want = expected_outcomes.pop_front();
                if (word_out.accepted !== want.accepted)
                    report_mismatch("accepted", word_out.accepted, want.accepted);
                if (word_out.delta_energy !== want.delta_energy)
                    report_mismatch("delta_energy", $signed(word_out.delta_energy),
                                    $signed(want.delta_energy));
                if (word_out.read_value !== want.read_value)
                    report_mismatch("read_value", word_out.read_value, want.read_value);
            end
            results_seen++;
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            word_out.ready <= 1'b0;
        end else begin
            word_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)
            || (psel && penable)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("lattice_gas_exchange_metropolis regression: fail");
                $finish;
            end
        end
    end

    // thresholds come out of reset at their defaults
    task automatic test_reset_thresholds();
        check_thresholds();
    endtask

    // directed words: field extremes, every mode, bit 0 of occupancy, self neighbour,
    // random just under and equal to a threshold
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(MODE_OCC_RD, 0, 0, 0, 0);
        send_word(MODE_OCC_RD, 1023, 3, 1023, '1);
        send_word(MODE_OCC_WR, 1023, 0, 10'h3ff, 0);
        send_word(MODE_OCC_WR, 5, 3, 10'h3fe, '1);
        send_word(MODE_OCC_RD, 1023, 0, 0, 0);
        send_word(MODE_OCC_RD, 5, 0, 0, 0);
        // site 1023 points at 0, 1, 2 and itself; site 0 at 1023, 1, 2, 3
        send_word(MODE_NBR_WR, 1023, 0, 0, '1);
        send_word(MODE_NBR_WR, 1023, 1, 1, 0);
        send_word(MODE_NBR_WR, 1023, 2, 2, 0);
        send_word(MODE_NBR_WR, 1023, 3, 1023, 0);
        send_word(MODE_NBR_WR, 0, 0, 1023, 0);
        send_word(MODE_NBR_WR, 0, 1, 1, 0);
        send_word(MODE_NBR_WR, 0, 2, 2, 0);
        send_word(MODE_NBR_WR, 0, 3, 3, 0);
        // self neighbour, then an energy rise of one above, at and below its threshold
        send_word(MODE_EXCHANGE, 1023, 3, 0, '1);
        send_word(MODE_EXCHANGE, 1023, 0, 0, '1);
        send_word(MODE_EXCHANGE, 1023, 0, 0, thr_model[0]);
        send_word(MODE_EXCHANGE, 1023, 0, 1023, thr_model[0] - t_rnd'(1));
        send_word(MODE_OCC_WR, 1, 0, 1, 0);
        send_word(MODE_OCC_WR, 2, 0, 1, 0);
        send_word(MODE_OCC_WR, 3, 0, 1, 0);
        send_word(MODE_EXCHANGE, 0, 0, 0, 0);
        send_word(MODE_EXCHANGE, 1023, 0, 0, '1);
        send_word(MODE_OCC_RD, 0, 0, 0, 0);
        send_word(MODE_OCC_RD, 1023, 0, 0, 0);
    endtask

    // one random word: mostly exchanges inside the loaded region, some noise anywhere
    task automatic send_random_word();
        int     pick;
        t_mode  m;
        t_site  s;
        t_dir   d;
        t_value v;
        pick = $urandom_range(99);
        s    = lattice_region[$urandom_range(lattice_region.size()-1)];
        d    = t_dir'($urandom_range(3));
        v    = t_value'($urandom_range(1023));
        if (pick < 55) begin
            m = MODE_EXCHANGE;
        end else if (pick < 70) begin
            m = MODE_OCC_WR;
        end else if (pick < 82) begin
            m = MODE_OCC_RD;
        end else if (pick < 92) begin
            m = MODE_NBR_WR;
            v = lattice_region[$urandom_range(lattice_region.size()-1)];
        end else begin
            m = t_mode'($urandom_range(3));
            s = t_site'($urandom_range(SITES-1));
        end
        // an exchange that would reach an unwritten entry becomes a read
        if (m == MODE_EXCHANGE && !exchange_safe(s, d)) m = MODE_OCC_RD;
        send_word(m, s, d, v, draw_uniform());
    endtask

    // program a threshold setting, load a fresh random region, then random words
    task automatic test_lattice_phase(input t_thr_setting setting, input int tx_idle,
                                      input int rx_idle, input int n_words);
        t_thr_arr thr_set;
        for (int i = 0; i < THR_COUNT; i++) begin
            case (setting)
                THR_RANDOM:    thr_set[i] = t_rnd'($urandom);
                THR_EVEN_ZERO: thr_set[i] = i[0] ? '1 : '0;
                default:       thr_set[i] = i[0] ? '0 : '1;
            endcase
        end
        wait_drained();
        for (int i = 0; i < THR_COUNT; i++) begin
            apb_write(i, thr_set[i]);
            thr_model[i] = thr_set[i];
        end
        check_thresholds();
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        lattice_region.delete();
        for (int i = 0; i < REGION_SITES; i++)
            lattice_region.push_back(t_site'($urandom_range(SITES-1)));
        // neighbour entries inside the region, self neighbours allowed
        foreach (lattice_region[i])
            for (int k = 0; k < NBR_SLOTS; k++)
                send_word(MODE_NBR_WR, lattice_region[i], t_dir'(k),
                          lattice_region[$urandom_range(REGION_SITES-1)], t_rnd'($urandom));
        foreach (lattice_region[i])
            send_word(MODE_OCC_WR, lattice_region[i], t_dir'($urandom_range(3)),
                      t_value'($urandom_range(1023)), t_rnd'($urandom));
        repeat (n_words) send_random_word();
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (12) send_random_word();
    endtask

    initial begin
        mismatch_count = 0;
        results_seen   = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_request   = 0;
        hold_left      = 0;
        stuck_cycles   = 0;
        thr_model      = THR_RESET;
        foreach (occ_model[i]) occ_model[i] = 1'b0;
        foreach (nbr_loaded[i]) nbr_loaded[i] = 1'b0;

        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        word_in.valid     <= 1'b0;
        word_in.mode      <= MODE_NBR_WR;
        word_in.site      <= '0;
        word_in.direction <= '0;
        word_in.value     <= '0;
        word_in.random    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_thresholds();
        test_directed_cases();
        test_lattice_phase(THR_RANDOM, 12, 55, 95);
        test_lattice_phase(THR_EVEN_ZERO, 55, 12, 95);
        test_lattice_phase(THR_ODD_ZERO, 0, 0, 95);
        test_output_backpressure();

        // drain, then watch for stray result words
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("lattice_gas_exchange_metropolis regression: pass");
        else
            $display("lattice_gas_exchange_metropolis regression: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lge_pkg.sv
hw/rtl/lge_if.sv
hw/rtl/lge_ram.sv
hw/rtl/lge_cfg_regs.sv
hw/rtl/lge_energy.sv
hw/rtl/lge_ctrl.sv
hw/rtl/lattice_gas_exchange_metropolis.sv
tb/tb_top.sv
